### sv/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared types, constants and binary32 arithmetic helpers for the fast
// reciprocal square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

    typedef logic [31:0] t_word;

    localparam t_word MAGIC     = 32'h5f37_59df;
    localparam t_word F32_HALF  = 32'h3f00_0000;
    localparam t_word F32_1P5   = 32'h3fc0_0000;
    localparam t_word QUIET_BIT = 32'h0040_0000;

    function automatic logic is_nan(input t_word b);
        return (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    endfunction

    // position of the most significant set bit
    function automatic logic [5:0] msb_pos(input logic [63:0] v);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

    // n has its leading one at bit 47; er is the biased exponent of n[47]
    function automatic t_word round_pack(input logic s, input logic signed [11:0] er,
                                         input logic [47:0] n, input logic st);
        logic [95:0]       wide;
        logic [6:0]        sh;
        logic [7:0]        epack;
        logic [23:0]       m;
        logic              g;
        logic              st2;
        logic              rnd;
        logic [30:0]       sum;
        if (er >= 12'sd255) begin
            return {s, 8'hff, 23'd0};
        end
        if (er >= 12'sd1) begin
            sh    = 7'd0;
            epack = 8'(er - 12'sd1);
        end else begin
            sh    = (er < -12'sd46) ? 7'd48 : 7'(12'sd1 - er);
            epack = 8'd0;
        end
        wide = {n, 48'd0} >> sh;
        m    = wide[95:72];
        g    = wide[71];
        st2  = (|wide[70:0]) | st;
        rnd  = g & (st2 | m[0]);
        sum  = {epack, 23'd0} + {7'd0, m} + {30'd0, rnd};
        return {s, sum};
    endfunction

    function automatic t_word fp_mul(input t_word a, input t_word b);
        logic               s;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [47:0]        p;
        logic [5:0]         k;
        logic [47:0]        n;
        logic signed [11:0] er;
        s = a[31] ^ b[31];
        if (a[30:23] == 8'hff || b[30:23] == 8'hff) begin
            return {s, 8'hff, 23'd0};
        end
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
            return {s, 31'd0};
        end
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        p  = ma * mb;
        k  = msb_pos({16'd0, p});
        n  = p << (6'd47 - k);
        er = 12'(k) + 12'(ea) + 12'(eb) - 12'sd173;
        return round_pack(s, er, n, 1'b0);
    endfunction

    function automatic t_word fp_add(input t_word a_in, input t_word b_in);
        t_word              a;
        t_word              b;
        logic               eff_sub;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [7:0]         d;
        logic [5:0]         dcap;
        logic [99:0]        bw;
        logic [50:0]        av;
        logic [50:0]        bv;
        logic [50:0]        sv;
        logic [5:0]         k;
        logic [50:0]        n;
        logic signed [11:0] er;
        if (a_in[30:23] == 8'hff) begin
            return a_in;
        end
        if (b_in[30:23] == 8'hff) begin
            return b_in;
        end
        if (b_in[30:0] > a_in[30:0]) begin
            a = b_in;
            b = a_in;
        end else begin
            a = a_in;
            b = b_in;
        end
        eff_sub = a[31] ^ b[31];
        ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        d    = ea - eb;
        dcap = (d > 8'd50) ? 6'd50 : 6'(d);
        av   = {1'b0, |a[30:23], a[22:0], 26'd0};
        bw   = {|b[30:23], b[22:0], 26'd0, 50'd0} >> dcap;
        bv   = {1'b0, bw[99:51], bw[50] | (|bw[49:0])};
        sv   = eff_sub ? (av - bv) : (av + bv);
        if (sv == 51'd0) begin
            return eff_sub ? 32'd0 : {a[31], 31'd0};
        end
        k  = msb_pos({13'd0, sv});
        n  = sv << (6'd50 - k);
        er = 12'(ea) + 12'(k) - 12'sd49;
        return round_pack(a[31], er, n[50:3], |n[2:0]);
    endfunction

endpackage

### sv/fisr_if.sv
// ----------------------------------------------------------------------------
// fisr_if
// Valid/ready channels for input operands and results.
// ----------------------------------------------------------------------------
interface fisr_in_if;
    logic            valid;
    logic            ready;
    fisr_pkg::t_word x_bits;
    modport source (output valid, output x_bits, input ready);
    modport sink   (input valid, input x_bits, output ready);
endinterface

interface fisr_out_if;
    logic            valid;
    logic            ready;
    fisr_pkg::t_word rsqrt_bits;
    modport source (output valid, output rsqrt_bits, input ready);
    modport sink   (input valid, input rsqrt_bits, output ready);
endinterface

### sv/fast_inverse_sqrt_float32.sv
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_float32
// Approximate 1/sqrt(x) on binary32 bit patterns: magic-constant guess and
// one Newton step, every float operation rounded to nearest even.
//
// Usage:
//   i_in  carries one operand per beat (x_bits), o_out one result per beat
//   (rsqrt_bits), in input order, one result per operand.
//   Five register stages: guess and 0.5*x, h*y, p*y, 1.5-q, y*f; the last
//   stage is the output register. Throughput is one beat per cycle while
//   the receiver does not stall; each stage holds one float
//   unit (a 24x24 multiply or an aligned add, plus normalize and round).
//   When the receiver stalls a valid result, the whole pipe holds and
//   i_in.ready drops in the same cycle; nothing is lost or repeated.
//   Reset clears all stage valid bits; the pipe is empty and ready after.
//   NaN operands or NaN guesses bypass the arithmetic and return quieted.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_float32 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fisr_in_if.sink    i_in,
    fisr_out_if.source o_out
);

    logic [4:0]      r_vld;
    fisr_pkg::t_word r_y   [4];
    fisr_pkg::t_word r_acc [5];
    logic            r_byp [4];
    logic            adv;
    fisr_pkg::t_word n_y0;
    fisr_pkg::t_word n_byp_val;
    logic            n_byp;

    assign adv        = !r_vld[4] || o_out.ready;
    assign i_in.ready = adv;
    assign o_out.valid      = r_vld[4];
    assign o_out.rsqrt_bits = r_acc[4];

    always_comb begin
        n_y0      = fisr_pkg::MAGIC - {i_in.x_bits[31], i_in.x_bits[31:1]};
        n_byp     = fisr_pkg::is_nan(i_in.x_bits) || fisr_pkg::is_nan(n_y0);
        n_byp_val = fisr_pkg::is_nan(i_in.x_bits) ? (i_in.x_bits | fisr_pkg::QUIET_BIT)
                                                  : (n_y0 | fisr_pkg::QUIET_BIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[3:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_y[0]   <= n_byp ? n_byp_val : n_y0;
            r_byp[0] <= n_byp;
            r_acc[0] <= fisr_pkg::fp_mul(fisr_pkg::F32_HALF, i_in.x_bits);
            r_y[1]   <= r_y[0];
            r_byp[1] <= r_byp[0];
            r_acc[1] <= fisr_pkg::fp_mul(r_acc[0], r_y[0]);
            r_y[2]   <= r_y[1];
            r_byp[2] <= r_byp[1];
            r_acc[2] <= fisr_pkg::fp_mul(r_acc[1], r_y[1]);
            r_y[3]   <= r_y[2];
            r_byp[3] <= r_byp[2];
            r_acc[3] <= fisr_pkg::fp_add(fisr_pkg::F32_1P5, r_acc[2] ^ 32'h8000_0000);
            r_acc[4] <= r_byp[3] ? r_y[3] : fisr_pkg::fp_mul(r_y[3], r_acc[3]);
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(r_vld) && $stable(r_acc[4]))
        else $error("pipe moved while output stalled");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!r_vld[4] || o_out.ready))
        else $error("ready does not follow output stage");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == 5'd0)
        else $error("valid bits not cleared by reset");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted beat not captured");
`endif

endmodule
